/* design/rpa_pkg.sv */
package rpa_pkg;

    // Width of a register index on the ports and in the ordered lists.
    localparam int REG_W = 4;
    // Width of the exclusion mask on a save request.
    localparam int EXCL_W = 7;
    // Width of the spill stack offset.
    localparam int SPILL_W = 16;

    localparam logic [SPILL_W-1:0] SPILL_STEP = 16'd8;
    localparam logic [SPILL_W-1:0] SPILL_MAX  = 16'd65528;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;
    localparam int M_FIELD_W = REG_W + 1 + SPILL_W;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RESTORE = 2'd2,
        FUNC_SAVE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_ALLOCATED    = 3'd0,
        KIND_FREED        = 3'd1,
        KIND_FREE_IGNORED = 3'd2,
        KIND_RESTORED     = 3'd3,
        KIND_NOT_SPILLED  = 3'd4,
        KIND_SAVED        = 3'd5,
        KIND_NONE_SAVED   = 3'd6
    } kind_t;

    // One update of an ordered list: an optional removal at a position,
    // followed by an optional append at the back.
    typedef struct packed {
        logic             remove;
        logic [REG_W-1:0] pos;
        logic             append;
        logic [REG_W-1:0] data;
    } list_op_t;

endpackage

/* design/rpa_list.sv */
module rpa_list #(
    parameter int DEPTH = 12,
    parameter bit RESET_ORDER = 1'b0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rpa_pkg::list_op_t         op,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [rpa_pkg::REG_W-1:0] rd_data,
    output logic [rpa_pkg::REG_W-1:0] front,
    output logic [CNT_W-1:0]          count
);
    import rpa_pkg::*;

    logic [REG_W-1:0] entry_reg  [DEPTH];
    logic [REG_W-1:0] entry_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] app_idx;

    // Removal closes the gap by moving every later entry one place forward;
    // the append then lands just behind the last remaining entry.
    always_comb
    begin
        app_idx    = count_reg - CNT_W'(op.remove);
        count_next = app_idx + CNT_W'(op.append);
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (op.remove && (i < DEPTH - 1) && (i >= int'(op.pos)))
            begin
                entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
            if (op.append && (CNT_W'(i) == app_idx))
            begin
                entry_next[i] = op.data;
            end
        end
    end

    generate
        if (RESET_ORDER)
        begin : g_reset_order
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        entry_reg[i] <= REG_W'(i);
                    end
                end
                else
                begin
                    entry_reg <= entry_next;
                end
            end
        end
        else
        begin : g_no_reset
            always_ff @(posedge clk)
            begin
                entry_reg <= entry_next;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RESET_ORDER ? CNT_W'(DEPTH) : '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_data = entry_reg[rd_addr];
    assign front   = entry_reg[0];
    assign count   = count_reg;

endmodule

/* design/register_pool_allocator_with_spill.sv */
// Register pool allocator with first-in first-out spilling. The block keeps NUM_REGS registers
// split between an ordered free list and an ordered in-use list, and serves one request at a
// time from a stream slave port (func in s_tuser, the other fields in s_tdata). Allocate hands
// out the hinted register when it is free, otherwise the front of the free list; with no free
// register it spills the oldest register in use, advances the spill offset by 8 (saturating at
// 65528), marks the register spilled and hands it out again. Free moves a register in use to
// the back of the free list, restore clears a spilled mark, and save reports every caller-saved
// register that is in use and not excluded, one result each, the final one flagged by m_tlast.
// Every request produces at least one result. A single comparator walks the lists one position
// per cycle. A restore, a refused free or a save with nothing to save goes from acceptance
// straight to the emit state, an allocate without a usable hint or a spill passes through
// the remove state first, and an allocate with a free hint or a successful free searches its
// list in the scan state before that, over at most NUM_REGS - 1 positions before the match;
// a save examines the caller-saved registers in turn, emitting each result. The next request
// is taken once the last result sits in the output register, so a stalled result holds back
// only the result behind it, and the request that owns that result waits in the block
// meanwhile. No clearing pass follows reset.
module register_pool_allocator_with_spill #(
    parameter int NUM_REGS  = 12,
    parameter int SAVE_REGS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // hint_valid [0], hint_reg [4:1], target_reg [8:5], exclude_mask [15:9]
    input  logic [rpa_pkg::S_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [rpa_pkg::S_TUSER_W-1:0] s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // reg_index [3:0], did_spill [4], spill_offset [20:5], zero [23:21]
    output logic [rpa_pkg::M_TDATA_W-1:0] m_tdata,
    // kind [2:0]
    output logic [rpa_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import rpa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_REGS);
    localparam int CNT_W  = $clog2(NUM_REGS + 1);
    localparam int SAVE_N = (SAVE_REGS < NUM_REGS) ? SAVE_REGS : NUM_REGS;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_REMOVE = 5'b00100,
        ST_SAVE   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    // Request fields as they arrive.
    func_t             in_func;
    logic              in_hint_valid;
    logic [REG_W-1:0]  in_hint;
    logic [REG_W-1:0]  in_tgt;
    logic [EXCL_W-1:0] in_excl;

    // Sequencer and pool state.
    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [REG_W-1:0]    key_reg, key_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic                spill_reg, spill_next;
    logic [NUM_REGS-1:0] busy_mask_reg, busy_mask_next;
    logic [NUM_REGS-1:0] spilled_reg, spilled_next;
    logic [SPILL_W-1:0]  stack_reg, stack_next;
    logic [NUM_REGS-1:0] save_mask_reg, save_mask_next;

    // Result being assembled, then the output register.
    kind_t              res_kind_reg, res_kind_next;
    logic [REG_W-1:0]   res_index_reg, res_index_next;
    logic               res_spill_reg, res_spill_next;
    logic [SPILL_W-1:0] res_off_reg, res_off_next;
    logic               res_last_reg, res_last_next;

    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [REG_W-1:0]   m_index_reg, m_index_next;
    logic               m_spill_reg, m_spill_next;
    logic [SPILL_W-1:0] m_off_reg, m_off_next;
    logic               m_last_reg, m_last_next;

    // List ports.
    list_op_t         free_op, busy_op;
    logic [REG_W-1:0] free_rd, busy_rd;
    logic [REG_W-1:0] free_front, busy_front;
    logic [CNT_W-1:0] free_count, busy_count;

    // Helpers.
    logic                hint_free;
    logic                tgt_busy;
    logic                tgt_spilled;
    logic [NUM_REGS-1:0] save_cand;
    logic [NUM_REGS-1:0] save_left;
    logic [REG_W-1:0]    scan_data;
    logic [CNT_W-1:0]    scan_count;
    logic                scan_match;
    logic                scan_last;
    logic [SPILL_W-1:0]  stack_inc;
    logic                out_free;

    assign in_func       = func_t'(s_tuser);
    assign in_hint_valid = s_tdata[0];
    assign in_hint       = s_tdata[4:1];
    assign in_tgt        = s_tdata[8:5];
    assign in_excl       = s_tdata[15:9];

    rpa_list #(
        .DEPTH       (NUM_REGS),
        .RESET_ORDER (1'b1)
    ) u_free_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (free_op),
        .rd_addr (scan_reg),
        .rd_data (free_rd),
        .front   (free_front),
        .count   (free_count)
    );

    rpa_list #(
        .DEPTH       (NUM_REGS),
        .RESET_ORDER (1'b0)
    ) u_busy_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (busy_op),
        .rd_addr (scan_reg),
        .rd_data (busy_rd),
        .front   (busy_front),
        .count   (busy_count)
    );

    // A register belongs to exactly one list, so the in-use mask answers
    // membership questions at once; only positions need the list walk.
    always_comb
    begin
        hint_free = in_hint_valid && ({1'b0, in_hint} < (REG_W + 1)'(NUM_REGS))
                    && !busy_mask_reg[in_hint[IDX_W-1:0]];
        tgt_busy = ({1'b0, in_tgt} < (REG_W + 1)'(NUM_REGS))
                   && busy_mask_reg[in_tgt[IDX_W-1:0]];
        tgt_spilled = ({1'b0, in_tgt} < (REG_W + 1)'(NUM_REGS))
                      && spilled_reg[in_tgt[IDX_W-1:0]];
        // Caller-saved registers beyond the exclusion mask cannot be excluded.
        for (int i = 0; i < NUM_REGS; i++)
        begin
            save_cand[i] = (i < SAVE_N) && busy_mask_reg[i]
                           && !((i < EXCL_W) && in_excl[(i < EXCL_W) ? i : 0]);
        end
    end

    // The shared comparator: the allocate search runs over the free list,
    // the free search over the in-use list.
    assign scan_data  = (func_reg == FUNC_ALLOC) ? free_rd : busy_rd;
    assign scan_count = (func_reg == FUNC_ALLOC) ? free_count : busy_count;
    assign scan_match = (scan_data == key_reg);
    assign scan_last  = ((CNT_W'(scan_reg) + CNT_W'(1)) >= scan_count);
    assign save_left  = save_mask_reg & ~(NUM_REGS'(1) << scan_reg);
    assign stack_inc  = (stack_reg < SPILL_MAX) ? (stack_reg + SPILL_STEP) : SPILL_MAX;
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        spill_next     = spill_reg;
        busy_mask_next = busy_mask_reg;
        spilled_next   = spilled_reg;
        stack_next     = stack_reg;
        save_mask_next = save_mask_reg;
        res_kind_next  = res_kind_reg;
        res_index_next = res_index_reg;
        res_spill_next = res_spill_reg;
        res_off_next   = res_off_reg;
        res_last_next  = res_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_index_next   = m_index_reg;
        m_spill_next   = m_spill_reg;
        m_off_next     = m_off_reg;
        m_last_next    = m_last_reg;
        free_op        = '0;
        busy_op        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next      = in_func;
                    scan_next      = '0;
                    pos_next       = '0;
                    spill_next     = 1'b0;
                    res_spill_next = 1'b0;
                    res_off_next   = '0;
                    res_last_next  = 1'b1;
                    unique case (in_func)
                        FUNC_ALLOC:
                        begin
                            res_kind_next = KIND_ALLOCATED;
                            if (hint_free)
                            begin
                                key_next   = in_hint;
                                state_next = ST_SCAN;
                            end
                            else if (free_count != '0)
                            begin
                                key_next   = free_front;
                                state_next = ST_REMOVE;
                            end
                            else if (busy_count != '0)
                            begin
                                // Pool exhausted: the oldest register in use is spilled.
                                key_next   = busy_front;
                                spill_next = 1'b1;
                                state_next = ST_REMOVE;
                            end
                            else
                            begin
                                res_index_next = '0;
                                state_next     = ST_EMIT;
                            end
                        end
                        FUNC_FREE:
                        begin
                            key_next       = in_tgt;
                            res_index_next = in_tgt;
                            if (tgt_busy)
                            begin
                                res_kind_next = KIND_FREED;
                                state_next    = ST_SCAN;
                            end
                            else
                            begin
                                res_kind_next = KIND_FREE_IGNORED;
                                state_next    = ST_EMIT;
                            end
                        end
                        FUNC_RESTORE:
                        begin
                            res_index_next = in_tgt;
                            if (tgt_spilled)
                            begin
                                spilled_next[in_tgt[IDX_W-1:0]] = 1'b0;
                                res_kind_next = KIND_RESTORED;
                            end
                            else
                            begin
                                res_kind_next = KIND_NOT_SPILLED;
                            end
                            state_next = ST_EMIT;
                        end
                        FUNC_SAVE:
                        begin
                            save_mask_next = save_cand;
                            if (save_cand != '0)
                            begin
                                state_next = ST_SAVE;
                            end
                            else
                            begin
                                res_kind_next  = KIND_NONE_SAVED;
                                res_index_next = '0;
                                state_next     = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (scan_match || scan_last)
                begin
                    pos_next   = scan_reg;
                    state_next = ST_REMOVE;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end

            ST_REMOVE:
            begin
                res_index_next = key_reg;
                if (func_reg == FUNC_ALLOC)
                begin
                    busy_op.append = 1'b1;
                    busy_op.data   = key_reg;
                    if (spill_reg)
                    begin
                        // The victim moves from the front to the back of the in-use list.
                        busy_op.remove = 1'b1;
                        busy_op.pos    = '0;
                        stack_next     = stack_inc;
                        spilled_next[key_reg[IDX_W-1:0]] = 1'b1;
                        res_spill_next = 1'b1;
                        res_off_next   = stack_inc;
                    end
                    else
                    begin
                        free_op.remove = 1'b1;
                        free_op.pos    = REG_W'(pos_reg);
                        busy_mask_next[key_reg[IDX_W-1:0]] = 1'b1;
                    end
                end
                else
                begin
                    busy_op.remove = 1'b1;
                    busy_op.pos    = REG_W'(pos_reg);
                    free_op.append = 1'b1;
                    free_op.data   = key_reg;
                    busy_mask_next[key_reg[IDX_W-1:0]] = 1'b0;
                end
                state_next = ST_EMIT;
            end

            ST_SAVE:
            begin
                scan_next = scan_reg + IDX_W'(1);
                if (save_mask_reg[scan_reg])
                begin
                    res_kind_next  = KIND_SAVED;
                    res_index_next = REG_W'(scan_reg);
                    res_last_next  = (save_left == '0);
                    save_mask_next = save_left;
                    state_next     = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_index_next = res_index_reg;
                    m_spill_next = res_spill_reg;
                    m_off_next   = res_off_reg;
                    m_last_next  = res_last_reg;
                    state_next   = res_last_reg ? ST_IDLE : ST_SAVE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            busy_mask_reg <= '0;
            spilled_reg   <= '0;
            stack_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            busy_mask_reg <= busy_mask_next;
            spilled_reg   <= spilled_next;
            stack_reg     <= stack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        scan_reg      <= scan_next;
        spill_reg     <= spill_next;
        save_mask_reg <= save_mask_next;
        res_kind_reg  <= res_kind_next;
        res_index_reg <= res_index_next;
        res_spill_reg <= res_spill_next;
        res_off_reg   <= res_off_next;
        res_last_reg  <= res_last_next;
        m_kind_reg    <= m_kind_next;
        m_index_reg   <= m_index_next;
        m_spill_reg   <= m_spill_next;
        m_off_reg     <= m_off_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}}, m_off_reg, m_spill_reg, m_index_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Every register sits on exactly one of the two lists.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(free_count) + (CNT_W + 1)'(busy_count)) == (CNT_W + 1)'(NUM_REGS))
        else $error("free and in-use counts do not cover the pool");

    // The in-use mask tracks the in-use list.
    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_mask_reg) == int'(busy_count))
        else $error("in-use mask disagrees with the in-use count");

    // A spill happens only with the free list empty.
    a_spill_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE && func_reg == FUNC_ALLOC && spill_reg) |-> (free_count == '0))
        else $error("spill while a register is free");

    // The search never walks past the end of the list it searches.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_reg) < scan_count))
        else $error("list search beyond its count");

    // The spill offset only ever moves in whole steps.
    a_stack_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stack_reg & (SPILL_STEP - SPILL_W'(1))) == '0)
        else $error("spill offset not a whole number of steps");
`endif

endmodule
